// ===== sv/st_pkg.sv =====
package st_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH      = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 1'd1;

    localparam int CFG_DATA_BITS = 32;
    localparam int DEPTH_BITS    = 16;
    localparam int PHASE_BITS    = 32;
    localparam int SINE_BITS     = 16;

    localparam logic [DEPTH_BITS-1:0] DEPTH_FULL  = 16'd32768;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 16'd31130;
    localparam logic [PHASE_BITS-1:0] STEP_RESET  = 32'd97392;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic full;
        logic empty;
    } st_q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GAIN,
        BK_LEFT,
        BK_RIGHT,
        BK_DONE
    } st_back_state_t;

    // Full-wave sine entry, Q1.15 scaled by 32767. Quarter-wave symmetry,
    // Q30 angle, Taylor series to x^11 with truncating steps.
    function automatic logic signed [SINE_BITS-1:0] sine_entry(input int unsigned k,
                                                              input int unsigned addr_bits);
        int unsigned     qs;
        longint unsigned quarter;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          val;
        qs      = addr_bits - 2;
        quarter = 64'd1 << qs;
        quad    = (longint'(k) >> qs) & 64'd3;
        r       = longint'(k) & (quarter - 64'd1);
        if (quad[0])
        begin
            r = quarter - r;
        end
        x    = (r * HALF_PI_Q30) >> qs;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        val = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (val > 32767)
        begin
            val = 32767;
        end
        if (quad >= 64'd2)
        begin
            val = -val;
        end
        return val[SINE_BITS-1:0];
    endfunction

endpackage

// ===== sv/st_in_if.sv =====
interface st_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== sv/st_out_if.sv =====
interface st_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== sv/st_front.sv =====
module st_front
    import st_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int SINE_ADDR_BITS = 10,
    parameter int Q_WIDTH        = 2 * SAMPLE_BITS + SINE_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PHASE_BITS-1:0] phase_step,
    st_in_if.sink                 frame_in,
    input  st_q_status_t          q_status,
    output logic                  q_push,
    output logic [Q_WIDTH-1:0]    q_push_data
);

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;

    assign frame_in.ready = !q_status.full;
    assign q_push         = frame_in.valid && !q_status.full;

    // sine address taken from the phase before this frame's advance
    assign q_push_data = {frame_in.left_sample, frame_in.right_sample,
                          phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]};

    always_comb
    begin
        phase_next = phase_reg;
        if (q_push)
        begin
            phase_next = phase_reg + phase_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/st_queue.sv =====
module st_queue
    import st_pkg::*;
#(
    parameter int WIDTH = 42
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output st_q_status_t     status
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/st_back.sv =====
module st_back
    import st_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int SINE_ADDR_BITS = 10,
    parameter int Q_WIDTH        = 2 * SAMPLE_BITS + SINE_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DEPTH_BITS-1:0] depth,
    input  logic [Q_WIDTH-1:0]    q_head,
    input  st_q_status_t          q_status,
    output logic                  q_pop,
    st_out_if.source              frame_out
);

    localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;
    // multiplier operand A holds a sample or the depth; B holds gain or sine-32768
    localparam int MA_W = ((SAMPLE_BITS > 17) ? SAMPLE_BITS : 17) + 1;
    localparam int MB_W = 18;
    localparam int PW   = MA_W + MB_W;

    typedef logic signed [SINE_BITS-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            rom[k] = sine_entry(k, SINE_ADDR_BITS);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    st_back_state_t state_reg;
    st_back_state_t state_next;

    logic signed [SINE_BITS-1:0]   sine_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          prod_next;
    logic signed [MB_W-1:0]        gain_reg;
    logic signed [MB_W-1:0]        gain_next;
    logic signed [SAMPLE_BITS-1:0] left_res_reg;
    logic signed [SAMPLE_BITS-1:0] left_res_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    logic [DEPTH_BITS-1:0]         depth_sat;
    logic signed [MB_W-1:0]        sine_off;
    logic signed [MA_W-1:0]        mul_a;
    logic signed [MB_W-1:0]        mul_b;
    logic signed [PW-1:0]          product;
    logic signed [PW-1:0]          gain_adj;
    logic signed [PW-1:0]          gain_q;
    logic signed [PW-1:0]          gain_sum;
    logic signed [MB_W-1:0]        gain_calc;
    logic signed [PW-1:0]          scl_adj;
    logic signed [PW-1:0]          scl_q;
    logic signed [SAMPLE_BITS-1:0] scaled;
    logic                          out_free;
    logic                          load_out;

    assign depth_sat = (depth > DEPTH_FULL) ? DEPTH_FULL : depth;
    assign sine_off  = MB_W'(sine_reg) - MB_W'(32768);

    assign product = mul_a * mul_b;

    // gain = 32768 + trunc(prod / 65536), prod <= 0
    assign gain_adj  = prod_reg + (prod_reg[PW-1] ? PW'(65535) : PW'(0));
    assign gain_q    = gain_adj >>> 16;
    assign gain_sum  = gain_q + PW'(32768);
    assign gain_calc = gain_sum[MB_W-1:0];

    // sample result = trunc(prod / 32768)
    assign scl_adj = prod_reg + (prod_reg[PW-1] ? PW'(32767) : PW'(0));
    assign scl_q   = scl_adj >>> 15;
    assign scaled  = scl_q[SAMPLE_BITS-1:0];

    assign out_free = !out_valid_reg || frame_out.ready;

    always_comb
    begin
        state_next    = state_reg;
        q_pop         = 1'b0;
        load_out      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        prod_next     = prod_reg;
        gain_next     = gain_reg;
        left_res_next = left_res_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_GAIN;
                end
            end
            BK_GAIN:
            begin
                mul_a      = $signed(MA_W'(depth_sat));
                mul_b      = sine_off;
                prod_next  = product;
                state_next = BK_LEFT;
            end
            BK_LEFT:
            begin
                mul_a      = MA_W'(left_reg);
                mul_b      = gain_calc;
                gain_next  = gain_calc;
                prod_next  = product;
                state_next = BK_RIGHT;
            end
            BK_RIGHT:
            begin
                left_res_next = scaled;
                mul_a         = MA_W'(right_reg);
                mul_b         = gain_reg;
                prod_next     = product;
                state_next    = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (!q_status.empty)
                    begin
                        q_pop      = 1'b1;
                        state_next = BK_GAIN;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sine_reg  <= SINE_ROM[q_head[SINE_ADDR_BITS-1:0]];
            left_reg  <= q_head[Q_WIDTH-1 -: SAMPLE_BITS];
            right_reg <= q_head[Q_WIDTH-SAMPLE_BITS-1 -: SAMPLE_BITS];
        end
        prod_reg     <= prod_next;
        gain_reg     <= gain_next;
        left_res_reg <= left_res_next;
        if (load_out)
        begin
            left_out_reg  <= left_res_reg;
            right_out_reg <= scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign frame_out.valid     = out_valid_reg;
    assign frame_out.left_out  = left_out_reg;
    assign frame_out.right_out = right_out_reg;

endmodule

// ===== sv/stereo_tremolo.sv =====
// Stereo tremolo: scales each stereo frame by a sine-LFO gain 1 - d/2 + (d/2)*sin(phase).
//
// Channels: frame_in carries one beat per frame (left_sample, right_sample);
// frame_out returns one beat per frame (left_out, right_out), in order.
// Both use valid/ready; a beat moves on a clock edge with both high.
// Configuration: cfg_we/cfg_index/cfg_data write depth (index 0, Q1.15,
// saturated at full depth) or phase_step (index 1). Write only while idle.
//
// A frame accepted on frame_in is pushed into the queue, popped by the back
// end and shown on frame_out from the output register. The back end runs one
// multiplier three times per frame (gain, left, right), then a DONE state hands
// the result to the output register; that multiplier sets the rate, as no new
// frame starts before the last is through. A two-beat queue lets the front
// keep taking frames (and advancing the LFO phase) while the back end is busy.
//
// Stall: while frame_out.ready is low the result holds in the output
// register, the back end parks, the queue fills and then frame_in.ready
// drops. Nothing is lost or repeated.
// Reset: phase goes to zero, depth and phase_step to their defaults,
// queue and output register empty.
module stereo_tremolo
    import st_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    st_in_if.sink                    frame_in,
    st_out_if.source                 frame_out
);

    localparam int Q_WIDTH = 2 * SAMPLE_BITS + SINE_ADDR_BITS;

    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;

    logic                  q_push;
    logic [Q_WIDTH-1:0]    q_push_data;
    logic                  q_pop;
    logic [Q_WIDTH-1:0]    q_head;
    st_q_status_t          q_status;

    // config registers
    always_comb
    begin
        depth_next = depth_reg;
        step_next  = step_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEPTH:      depth_next = cfg_data[DEPTH_BITS-1:0];
                CFG_PHASE_STEP: step_next  = cfg_data[PHASE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
            step_reg  <= STEP_RESET;
        end
        else
        begin
            depth_reg <= depth_next;
            step_reg  <= step_next;
        end
    end

    // front: takes beats, stamps each with its sine address, steps the LFO
    st_front #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .Q_WIDTH        (Q_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_step  (step_reg),
        .frame_in    (frame_in),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    st_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // back: sine lookup, gain, and the two sample products on one multiplier
    st_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .Q_WIDTH        (Q_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth     (depth_reg),
        .q_head    (q_head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .frame_out (frame_out)
    );

    // queue never overflows and the back end never reads an empty slot
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // an accepted beat with no pop in the same cycle leaves the queue non-empty on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> !q_status.empty)
        else $error("accepted beat not queued");

endmodule

// ===== tb/stereo_tremolo_checker.sv =====
`timescale 1ns / 1ps

// Watches both frame channels and the config port, predicts each output frame
// from its own copy of depth, phase_step and the LFO phase, and compares.
module stereo_tremolo_checker
    import st_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    st_in_if                         frame_in,
    st_out_if                        frame_out,
    output int                       mismatches,
    output int                       frames_pending
);

    localparam int ROM_SIZE   = 1 << SINE_ADDR_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } tremolo_frame_t;

    int                     sine_table [0:ROM_SIZE-1];
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic [PHASE_BITS-1:0]  step_reg;
    logic [PHASE_BITS-1:0]  lfo_phase;
    tremolo_frame_t         expected_frames [$];
    tremolo_frame_t         want_frame;

    // Q1.15 sine, scaled by 32767: quarter-wave fold, Q30 angle, odd Taylor
    // terms up to x^11, each step truncated.
    function automatic int sine_q15(input int unsigned idx);
        int unsigned     qshift;
        int unsigned     quad;
        int unsigned     n;
        longint unsigned qlen;
        longint unsigned seg;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint          acc;
        longint          mag;
        qshift = SINE_ADDR_BITS - 2;
        qlen   = 64'd1 << qshift;
        quad   = (idx >> qshift) & 3;
        seg    = idx & (qlen - 64'd1);
        if (quad[0])
        begin
            seg = qlen - seg;
        end
        ang  = (seg * HALF_PI_Q30) >> qshift;
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (n = 1; n <= 5; n++)
        begin
            term = ((term * ang2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n[0])
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        mag = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (mag > 32767)
        begin
            mag = 32767;
        end
        if (quad >= 2)
        begin
            mag = -mag;
        end
        return int'(mag);
    endfunction

    // Gain at the current phase, then both samples scaled, truncated to zero.
    function automatic tremolo_frame_t tremolo_scale(input logic signed [SAMPLE_BITS-1:0] l_in,
                                                     input logic signed [SAMPLE_BITS-1:0] r_in);
        longint         dep;
        longint         s;
        longint         gain;
        longint         l_prod;
        longint         r_prod;
        tremolo_frame_t f;
        dep    = (depth_reg > DEPTH_FULL) ? longint'(DEPTH_FULL) : longint'(depth_reg);
        s      = longint'(sine_table[lfo_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]]);
        gain   = 64'sd32768 + (dep * (s - 64'sd32768)) / 64'sd65536;
        l_prod = (longint'(l_in) * gain) / 64'sd32768;
        r_prod = (longint'(r_in) * gain) / 64'sd32768;
        f.left_out  = l_prod[SAMPLE_BITS-1:0];
        f.right_out = r_prod[SAMPLE_BITS-1:0];
        return f;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        for (int k = 0; k < ROM_SIZE; k++)
        begin
            sine_table[k] = sine_q15(k);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= DEPTH_RESET;
            step_reg       <= STEP_RESET;
            lfo_phase      <= '0;
            frames_pending <= 0;
            expected_frames.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEPTH)
                begin
                    depth_reg <= cfg_data[DEPTH_BITS-1:0];
                end
                else if (cfg_index == CFG_PHASE_STEP)
                begin
                    step_reg <= cfg_data[PHASE_BITS-1:0];
                end
            end
            // output beat first: it always belongs to an older frame
            if (frame_out.valid && frame_out.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    report_mismatch("unexpected beat, left_out", frame_out.left_out, 0);
                end
                else
                begin
                    want_frame = expected_frames.pop_front();
                    if (frame_out.left_out !== want_frame.left_out)
                    begin
                        report_mismatch("left_out", frame_out.left_out, want_frame.left_out);
                    end
                    if (frame_out.right_out !== want_frame.right_out)
                    begin
                        report_mismatch("right_out", frame_out.right_out,
                                        want_frame.right_out);
                    end
                end
            end
            if (frame_in.valid && frame_in.ready)
            begin
                expected_frames.push_back(tremolo_scale(frame_in.left_sample,
                                                        frame_in.right_sample));
                lfo_phase <= lfo_phase + step_reg;
            end
            frames_pending <= expected_frames.size();
        end
    end

endmodule

// ===== tb/stereo_tremolo_test.sv =====
`timescale 1ns / 1ps

// Top of the tremolo bench: clock, reset, frame stimulus, result sink with
// random back-pressure, and the verdict. All checking lives in the checker.
module stereo_tremolo_test
    import st_pkg::*;
;

    localparam int SINE_ADDR_BITS  = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int RAND_PHASES     = 6;
    localparam int FRAMES_PER_RUN  = 212;  // frames per random config phase
    localparam int SQUEEZE_CYCLES  = 200;  // long sink hold-off
    localparam int SQUEEZE_FRAMES  = 100;  // back-to-back beats offered meanwhile
    localparam int SETTLE_CYCLES   = 12;   // extra wait once the queue has drained, as margin
    localparam int TIMEOUT_NS      = 5_000_000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic squeeze_req;
    bit   squeeze_done;
    int   mismatches;
    int   frames_pending;

    st_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) frame_in ();
    st_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) frame_out ();

    stereo_tremolo #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_in  (frame_in),
        .frame_out (frame_out)
    );

    stereo_tremolo_checker #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frame_in       (frame_in),
        .frame_out      (frame_out),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    // 100 MHz
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case a beat never shows up.
    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Corner frames for the directed part: full-scale positive and negative,
    // zero, +/-1, half scale, and both channels pinned at the same rail.
    function automatic logic [2*SAMPLE_BITS-1:0] corner_frame(input int n);
        case (n)
            0:       return {16'h8000, 16'h7FFF};
            1:       return {16'h7FFF, 16'h8000};
            2:       return {16'h0000, 16'h0000};
            3:       return {16'hFFFF, 16'h0001};
            4:       return {16'h0001, 16'hFFFF};
            5:       return {16'h4000, 16'hC000};
            6:       return {16'h8000, 16'h8000};
            default: return {16'h7FFF, 16'h7FFF};
        endcase
    endfunction

    // Mostly uniform samples, with rails and small values mixed in so the
    // truncation toward zero is hit near zero too.
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            1:       return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Depth word: upper bits are junk on purpose, only the low 16 count.
    // Values above full depth must saturate.
    function automatic logic [CFG_DATA_BITS-1:0] rand_depth_word();
        logic [DEPTH_BITS-1:0] dv;
        case ($urandom_range(0, 7))
            0:       dv = '0;
            1:       dv = DEPTH_FULL;
            2:       dv = 16'hFFFF;
            3, 4:    dv = DEPTH_BITS'($urandom_range(0, 32768));
            5:       dv = DEPTH_BITS'($urandom_range(32769, 65535));
            default: dv = DEPTH_BITS'($urandom);
        endcase
        return {16'($urandom), dv};
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_step_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;  // one tick backward each frame
            2:       return 32'h8000_0000;  // half turn per frame
            3, 4:    return CFG_DATA_BITS'($urandom_range(0, 400000));
            5:       return 32'h0040_0000;  // one table entry per frame
            default: return CFG_DATA_BITS'($urandom);
        endcase
    endfunction

    // Sender gap after a beat. Style 0 never idles, style 2 stays short, and
    // the others are mostly short with the odd long gap.
    function automatic int next_gap(input int style);
        case (style)
            0:       return 0;
            2:       return $urandom_range(0, 5);
            default:
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    return $urandom_range(10, 40);
                end
                return $urandom_range(0, 2);
            end
        endcase
    endfunction

    // Offer one frame, hold it until taken. valid stays up when no gap
    // follows, so back-to-back beats never see valid drop.
    task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l_smp,
                              input logic signed [SAMPLE_BITS-1:0] r_smp,
                              input int gap);
        frame_in.valid        <= 1'b1;
        frame_in.left_sample  <= l_smp;
        frame_in.right_sample <= r_smp;
        @(posedge clk);
        while (!frame_in.ready)
        begin
            @(posedge clk);
        end
        if (gap > 0)
        begin
            frame_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected frame has come back, then
    // wait SETTLE_CYCLES more for the pipe to go quiet.
    task automatic drain_all();
        frame_in.valid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers back to back; we drops only after the second write.
    task automatic load_settings(input logic [CFG_DATA_BITS-1:0] depth_word,
                                 input logic [CFG_DATA_BITS-1:0] step_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEPTH;
        cfg_data  <= depth_word;
        @(posedge clk);
        cfg_index <= CFG_PHASE_STEP;
        cfg_data  <= step_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result sink. Ready pattern changes in bursts: always ready, mostly
    // ready, sparse, or a solid stall. Once the stimulus raises squeeze_req
    // the sink holds off for SQUEEZE_CYCLES so the queue fills and the input
    // side has to stall.
    initial
    begin : result_sink
        int style;
        int span;
        int c;
        frame_out.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                frame_out.ready <= 1'b0;
                for (c = 0; c < SQUEEZE_CYCLES; c++)
                begin
                    @(posedge clk);
                end
            end
            style = $urandom_range(0, 9);
            span  = (style == 9) ? $urandom_range(10, 40) : $urandom_range(20, 80);
            for (c = 0; c < span; c++)
            begin
                if (style <= 3)
                begin
                    frame_out.ready <= 1'b1;
                end
                else if (style <= 6)
                begin
                    frame_out.ready <= ($urandom_range(0, 3) != 0);
                end
                else if (style <= 8)
                begin
                    frame_out.ready <= ($urandom_range(0, 9) < 3);
                end
                else
                begin
                    frame_out.ready <= 1'b0;
                end
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int k;
        int n;
        int style;
        int gap;
        logic [2*SAMPLE_BITS-1:0] cf;

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_DEPTH;
        cfg_data              <= '0;
        frame_in.valid        <= 1'b0;
        frame_in.left_sample  <= '0;
        frame_in.right_sample <= '0;
        squeeze_req           <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner frames under the reset settings, then at full
        // depth with a step of all ones (phase wraps on the first beat),
        // then with depth above full and a quarter-turn step so the sine
        // lands exactly on zero, peak and trough.
        for (n = 0; n < 8; n++)
        begin
            cf = corner_frame(n);
            send_frame(cf[31:16], cf[15:0], n % 3);
        end
        drain_all();
        load_settings({16'h0000, DEPTH_FULL}, 32'hFFFF_FFFF);
        for (n = 0; n < 8; n++)
        begin
            cf = corner_frame(n);
            send_frame(cf[31:16], cf[15:0], 0);
        end
        drain_all();
        load_settings(32'hA5A5_FFFF, 32'h4000_0000);
        for (n = 0; n < 8; n++)
        begin
            cf = corner_frame(7 - n);
            send_frame(cf[31:16], cf[15:0], n % 2);
        end
        drain_all();

        // Random phases. The first one runs at zero depth and zero step, so
        // the gain is exactly one; the second opens with the long sink stall
        // while beats keep coming back to back.
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                load_settings({16'($urandom), 16'h0000}, '0);
            end
            else
            begin
                load_settings(rand_depth_word(), rand_step_word());
            end
            if (ph == 1)
            begin
                squeeze_req <= 1'b1;
            end
            style = 0;
            for (k = 0; k < FRAMES_PER_RUN; k++)
            begin
                if (k % 40 == 0)
                begin
                    style = $urandom_range(0, 3);
                end
                gap = (ph == 1 && k < SQUEEZE_FRAMES) ? 0 : next_gap(style);
                send_frame(rand_sample(), rand_sample(), gap);
                // now and then, let everything drain mid-phase
                if ($urandom_range(0, 149) == 0)
                begin
                    drain_all();
                end
            end
            drain_all();
        end

        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
